[hw/rtl/pol_pkg.sv]
// Shared types and constants for the positional ordered list.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package pol_pkg;

   // Default sizing
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths at the ports
   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_INS_FRONT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INS_BACK  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INS_POS   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DEL_FRONT = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_DEL_BACK  = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_DEL_POS   = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the accepted item
      logic exec;   // apply it to the cells and load the result register
   } pol_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/pol_ctrl.sv]
// Controller for the positional ordered list: accept / execute sequencing
// and result valid. Depends on pol_pkg.
`default_nettype none

module pol_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      pol_pkg::pol_cmd_type cmd
);
   import pol_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // take an item when idle and the result register is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pol_dpath.sv]
// Datapath for the positional ordered list: request registers, shifting
// cell chain, entry count and result register. Depends on pol_pkg.
`default_nettype none

module pol_dpath #(
   parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pol_pkg::pol_cmd_type                cmd,
   input  wire logic [pol_pkg::TYPE_W-1:0]          req_type,
   input  wire logic signed [pol_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic [pol_pkg::POS_W-1:0]           req_position,
   output      logic [pol_pkg::STATUS_W-1:0]        rsp_status,
   output      logic signed [pol_pkg::VALUE_W-1:0]  rsp_removed_value,
   output      logic [pol_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import pol_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // captured request
   logic [TYPE_W-1:0]         type_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;

   // list state
   logic [DATA_WIDTH-1:0] cell_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]      count_ff, count_in;

   // result register
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic [COUNT_W-1:0]        count_out_ff;

   logic [CMP_W-1:0]      pos_ext, cnt_ext, count_in_ext;
   logic [DATA_WIDTH-1:0] value_store;
   logic [DATA_WIDTH-1:0] removed_cell;
   logic [IDX_W-1:0]      idx;
   logic                  do_ins, do_del;

   assign pos_ext     = CMP_W'(pos_ff);
   assign cnt_ext     = CMP_W'(count_ff);
   assign value_store = DATA_WIDTH'(value_ff);   // sign-extend or truncate

   // decode: status, target index, insert / delete strobes
   always_comb begin
      status_in = ST_OK;
      idx       = '0;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      case (type_ff) inside
         REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
            if (cnt_ext >= CMP_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else if (type_ff == REQ_INS_FRONT) begin
               do_ins = 1'b1;
            end else if (type_ff == REQ_INS_BACK) begin
               idx    = cnt_ext[IDX_W-1:0];
               do_ins = 1'b1;
            end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               status_in = ST_BADPOS;
            end else begin
               idx    = IDX_W'(pos_ext - CMP_W'(1));
               do_ins = 1'b1;
            end
         end
         REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
            if (cnt_ext == '0) begin
               status_in = ST_EMPTY;
            end else if (type_ff == REQ_DEL_FRONT) begin
               do_del = 1'b1;
            end else if (type_ff == REQ_DEL_BACK) begin
               idx    = IDX_W'(cnt_ext - CMP_W'(1));
               do_del = 1'b1;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
               status_in = ST_BADPOS;
            end else begin
               idx    = IDX_W'(pos_ext - CMP_W'(1));
               do_del = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;   // unused codes leave the list alone
         end
      endcase
   end

   // cell chain: each cell looks only at itself, its two neighbors and the new value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (do_ins) begin
            if (IDX_W'(i) == idx) begin
               cell_in[i] = value_store;
            end else if (i > 0 && IDX_W'(i) > idx) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_del) begin
            if (i < CAPACITY - 1 && IDX_W'(i) >= idx) begin
               cell_in[i] = cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   // value leaving the list
   always_comb begin
      removed_cell = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (IDX_W'(i) == idx) begin
            removed_cell = cell_ff[i];
         end
      end
   end

   assign removed_in = do_del ? VALUE_W'(removed_cell) : '0;  // zero-extend or truncate

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_in_ext = CMP_W'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         value_ff <= req_item_value;
         pos_ff   <= req_position;
      end
      if (cmd.exec) begin
         cell_ff      <= cell_in;
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         count_out_ff <= count_in_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_count   = count_out_ff;

endmodule

`default_nettype wire

[hw/rtl/positional_ordered_list.sv]
// Positional ordered list: up to CAPACITY signed entries kept front first.
// Result valid after the item is captured and then executed in the execute state.
// A new item is taken only once the last one has executed (one shift of the cell chain).
// Reset (synchronous, active high) empties the list and drops any pending result;
// cell contents are not cleared, only cells below the count are ever read.
`default_nettype none

module positional_ordered_list #(
   parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,   // 2..31 entries
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF  // stored bits per entry
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [pol_pkg::TYPE_W-1:0]          req_type,
   input  wire logic signed [pol_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic [pol_pkg::POS_W-1:0]           req_position,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [pol_pkg::STATUS_W-1:0]        rsp_status,
   output      logic signed [pol_pkg::VALUE_W-1:0]  rsp_removed_value,
   output      logic [pol_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import pol_pkg::*;

   pol_cmd_type cmd;

   // Controller: takes an item when idle and the result register is free
   // (or being drained in the same cycle), then runs the execute state that
   // loads the result register.
   pol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: the cells from the target index on shift by one in the execute cycle,
   // opening a gap for an insert or closing one for a delete.
   pol_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

`default_nettype wire

[dv/positional_ordered_list_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for positional_ordered_list: directed edge cases,
// back-pressure and a random request mix, checked against an in-bench list model.
// Depends on pol_pkg and the positional_ordered_list RTL.

module positional_ordered_list_test;
   import pol_pkg::*;

   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;

   // Request codes 6 and 7 have no meaning; the block must ignore them.
   localparam logic [TYPE_W-1:0] REQ_UNUSED_A = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_UNUSED_B = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MOST_NEG = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MOST_POS = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VAL_ALL_ONES = -32'sd1;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] removed;
      logic [COUNT_W-1:0]        count;
   } list_result_type;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_mode_type;

   // DUT ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [TYPE_W-1:0]         req_type = REQ_INS_FRONT;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [COUNT_W-1:0]        rsp_entry_count;

   // Shadow copy of the list, front at index 0
   logic signed [VALUE_W-1:0] list_cells [LIST_DEPTH];
   int                        list_len = 0;

   list_result_type pending_results [$];
   int  fault_count   = 0;
   int  cycle_count   = 0;
   int  hold_request  = 0;   // long receiver hold-off, picked up by the receiver
   bit  sender_idles  = 1'b1;
   bit  quiet_end     = 1'b0; // no idling on either side near the end
   int  tx_calm       = 0;

   positional_ordered_list DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the shadow list and return the answer it must give.
   // Full and empty checks come before the position check.
   function automatic list_result_type predict_request(input logic [TYPE_W-1:0] kind,
                                                       input logic signed [VALUE_W-1:0] value,
                                                       input logic [POS_W-1:0] slot);
      list_result_type r;
      int at;
      int i;
      r.status  = ST_OK;
      r.removed = '0;
      case (kind)
         REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
            if (list_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (kind == REQ_INS_POS && (slot == 0 || int'(slot) > list_len + 1)) begin
               r.status = ST_BADPOS;
            end else begin
               at = (kind == REQ_INS_FRONT) ? 0 :
                    (kind == REQ_INS_BACK)  ? list_len : int'(slot) - 1;
               for (i = list_len; i > at; i--)
                  list_cells[i] = list_cells[i-1];
               list_cells[at] = value;
               list_len++;
            end
         end
         REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else if (kind == REQ_DEL_POS && (slot == 0 || int'(slot) > list_len)) begin
               r.status = ST_BADPOS;
            end else begin
               at = (kind == REQ_DEL_FRONT) ? 0 :
                    (kind == REQ_DEL_BACK)  ? list_len - 1 : int'(slot) - 1;
               r.removed = list_cells[at];
               for (i = at; i < list_len - 1; i++)
                  list_cells[i] = list_cells[i+1];
               list_len--;
            end
         end
         default: ;  // unused codes: list untouched, all-zero answer apart from count
      endcase
      r.count = COUNT_W'(list_len);
      return r;
   endfunction

   // Prediction on accepted requests and checking of accepted results share
   // one process so prediction always comes before checking.
   always @(posedge clock) begin : check_results
      list_result_type seen;
      list_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_results.push_back(predict_request(req_type, req_item_value, req_position));
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_status, rsp_removed_value, rsp_entry_count};
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result: status %0d removed %0d count %0d",
                           seen.status, seen.removed, seen.count);
            end else begin
               want = pending_results.pop_front();
               if (seen.status !== want.status || seen.removed !== want.removed ||
                   seen.count !== want.count) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("mismatch: status exp %0d got %0d, ",
                              want.status, seen.status,
                              "removed exp %0d got %0d, count exp %0d got %0d",
                              want.removed, seen.removed, want.count, seen.count);
               end
            end
         end
      end
   end

   // Result receiver: random stall bursts, calm stretches, and long hold-offs on request.
   always @(posedge clock) begin : drive_rsp_ready
      static int rx_hold = 0;
      static int rx_gap  = 0;
      static int rx_calm = 0;
      int pick;
      if (hold_request > 0) begin
         rx_hold      = hold_request;
         hold_request = 0;
      end
      pick = $urandom_range(0, 15);
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else if (rx_gap > 0) begin
         rsp_ready <= 1'b0;
         rx_gap--;
      end else if (quiet_end || rx_calm > 0) begin
         rsp_ready <= 1'b1;
         if (rx_calm > 0)
            rx_calm--;
      end else if (pick < 2) begin
         rsp_ready <= 1'b0;
         rx_gap = $urandom_range(1, 5) - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (pick == 2)
            rx_calm = $urandom_range(20, 60);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // Offer one item and hold it until accepted; then maybe idle for a burst.
   task automatic send_request(input logic [TYPE_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] slot);
      int gap;
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_item_value <= value;
      req_position   <= slot;
      do @(posedge clock); while (!req_ready);
      if (tx_calm > 0) begin
         tx_calm--;
      end else if (sender_idles && !quiet_end) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               gap = $urandom_range(1, 5);
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            2: tx_calm = $urandom_range(10, 30);
            default: ;
         endcase
      end
   endtask

   // Stop offering items, then wait until every expected result is back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return VAL_MOST_NEG;
         1:       return VAL_MOST_POS;
         2:       return '0;
         3:       return VAL_ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal positions for the current fill, with zero, one-past and
   // anything up to the field maximum mixed in.
   function automatic logic [POS_W-1:0] pick_position(input logic [TYPE_W-1:0] kind);
      int top;
      top = (kind == REQ_INS_POS) ? list_len + 1 : list_len;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return POS_W'($urandom_range(0, 31));
         2:       return POS_W'((top + 1 > 31) ? 31 : top + 1);
         default: return POS_W'($urandom_range(1, (top < 1) ? 1 : top));
      endcase
   endfunction

   function automatic logic [TYPE_W-1:0] pick_kind(input mix_mode_type mode);
      int roll;
      int ins_share;
      roll      = $urandom_range(0, 99);
      ins_share = (mode == MIX_GROW) ? 75 : (mode == MIX_SHRINK) ? 25 : 50;
      if (roll < 2)
         return ($urandom_range(0, 1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
      if (roll < ins_share) begin
         case ($urandom_range(0, 2))
            0:       return REQ_INS_FRONT;
            1:       return REQ_INS_BACK;
            default: return REQ_INS_POS;
         endcase
      end
      case ($urandom_range(0, 2))
         0:       return REQ_DEL_FRONT;
         1:       return REQ_DEL_BACK;
         default: return REQ_DEL_POS;
      endcase
   endfunction

   task automatic send_random(input mix_mode_type mode);
      logic [TYPE_W-1:0] kind;
      kind = pick_kind(mode);
      send_request(kind, pick_value(), pick_position(kind));
   endtask

   // Deletes on an empty list answer "empty" whatever the position.
   task automatic test_empty_list();
      send_request(REQ_DEL_FRONT, VAL_MOST_POS, 5'd1);
      send_request(REQ_DEL_BACK, VAL_MOST_NEG, 5'd1);
      send_request(REQ_DEL_POS, '0, 5'd0);
      send_request(REQ_DEL_POS, VAL_ALL_ONES, 5'd31);
   endtask

   task automatic test_unused_codes();
      send_request(REQ_UNUSED_A, VAL_ALL_ONES, 5'd31);
      send_request(REQ_UNUSED_B, VAL_MOST_NEG, 5'd1);
   endtask

   // Builds a five-entry list; covers front/back aliasing of positions.
   task automatic test_insert_positions();
      send_request(REQ_INS_POS, VAL_MOST_NEG, 5'd1);    // position 1 into empty list
      send_request(REQ_INS_POS, 32'sd77, 5'd0);         // position zero
      send_request(REQ_INS_POS, 32'sd78, 5'd3);         // count+2
      send_request(REQ_INS_POS, VAL_MOST_POS, 5'd2);    // count+1 is the back
      send_request(REQ_INS_FRONT, '0, 5'd31);
      send_request(REQ_INS_BACK, VAL_ALL_ONES, 5'd0);
      send_request(REQ_INS_POS, 32'sh5a5a_5a5a, 5'd2);  // middle
   endtask

   // Takes the five-entry list back down to empty, last entry included.
   task automatic test_delete_positions();
      send_request(REQ_DEL_POS, '0, 5'd6);              // count+1 is out of range
      send_request(REQ_DEL_POS, '0, 5'd0);
      send_request(REQ_DEL_POS, '0, 5'd3);
      send_request(REQ_DEL_FRONT, VAL_MOST_POS, 5'd0);
      send_request(REQ_DEL_BACK, '0, 5'd31);
      send_request(REQ_DEL_POS, '0, 5'd2);              // last position
      send_request(REQ_DEL_POS, '0, 5'd1);              // only remaining entry
   endtask

   // Fill to capacity, then every insert reports full before position is looked at.
   task automatic test_full_list();
      int i;
      for (i = 0; i < LIST_DEPTH; i++) begin
         case ($urandom_range(0, 2))
            0:       send_request(REQ_INS_FRONT, pick_value(), '0);
            1:       send_request(REQ_INS_BACK, pick_value(), '0);
            default: send_request(REQ_INS_POS, pick_value(), POS_W'($urandom_range(1, i + 1)));
         endcase
      end
      send_request(REQ_INS_FRONT, VAL_MOST_POS, 5'd1);
      send_request(REQ_INS_BACK, VAL_MOST_NEG, 5'd17);
      send_request(REQ_INS_POS, 32'sd1, 5'd0);
      send_request(REQ_INS_POS, 32'sd2, 5'd17);
      send_request(REQ_INS_POS, 32'sd3, 5'd31);
      send_request(REQ_DEL_POS, '0, 5'd17);             // one past the last entry
      send_request(REQ_DEL_POS, '0, 5'd16);
   endtask

   // Receiver holds off long enough for the block to back up into its input,
   // then the sender waits for everything to come back.
   task automatic test_backpressure();
      int i;
      sender_idles = 1'b0;
      hold_request = 80;
      for (i = 0; i < 30; i++)
         send_random(MIX_EVEN);
      sender_idles = 1'b1;
      wait_for_drain();
   endtask

   // Alternating grow/shrink/even segments sweep the fill level between empty and full.
   task automatic test_random_mix();
      int seg;
      int i;
      mix_mode_type mode;
      for (seg = 0; seg < 10; seg++) begin
         case (seg % 3)
            0:       mode = MIX_GROW;
            1:       mode = MIX_SHRINK;
            default: mode = MIX_EVEN;
         endcase
         if (seg == 5)
            wait_for_drain();
         if (seg == 9)
            quiet_end = 1'b1;
         for (i = 0; i < 40; i++)
            send_random(mode);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_unused_codes();
      test_insert_positions();
      test_delete_positions();
      test_full_list();
      test_backpressure();
      test_random_mix();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
